// ----- design/char_lcd_nibble_writer_defines.svh -----
// Assertion macros for the character LCD nibble writer modules.
// No dependencies; included by modules that check their own logic.
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLNW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clnw check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLNW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clnw check failed");

// The condition must hold at every clock edge outside reset.
`define CLNW_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("clnw check failed");

`endif

// ----- design/clnw_pkg.sv -----
// Shared types, constants and tables for the character LCD nibble writer.
// No dependencies; imported by every module of the block.
package clnw_pkg;

    // Field and register widths.
    localparam int CLNW_CFG_W     = 24;
    localparam int CLNW_ADDR_W    = 3;
    localparam int CLNW_DATA_W    = 32;
    localparam int CLNW_NUMBER_W  = 16;
    localparam int CLNW_DIGITS    = 5;
    localparam int CLNW_INIT_LEN  = 9;

    // Default parameter values.
    localparam int CLNW_COLUMNS     = 16;
    localparam int CLNW_QUEUE_DEPTH = 4;

    // Register reset values.
    localparam logic [CLNW_CFG_W-1:0] CLNW_STROBE_RESET = 24'd50000;

    // Register indexes, taken from address bit 2.
    localparam logic REG_STROBE_HIGH = 1'b0;
    localparam logic REG_STROBE_LOW  = 1'b1;

    // Display constants.
    localparam logic [7:0] ROW0_BASE  = 8'h80;
    localparam logic [7:0] ROW1_BASE  = 8'hC0;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Operation codes of an input request.
    typedef enum logic [2:0] {
        FUNC_CMD  = 3'd0,
        FUNC_DATA = 3'd1,
        FUNC_POS  = 3'd2,
        FUNC_NUM  = 3'd3,
        FUNC_INIT = 3'd4
    } func_t;

    // One byte waiting to be sent as two nibbles.
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic       last;
    } byte_entry_t;

    // Strobe timing handed to the back end.
    typedef struct packed {
        logic [CLNW_CFG_W-1:0] high_cycles;
        logic [CLNW_CFG_W-1:0] low_cycles;
    } strobe_cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SEND,
        F_INIT,
        F_CONV,
        F_SKIP,
        F_DIGITS
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EMIT,
        B_HIGH,
        B_LOW
    } back_state_t;

    // Fixed command bytes of the init sequence.
    function automatic logic [7:0] init_cmd(input logic [3:0] idx);
        logic [7:0] cmd;
        unique case (idx)
            4'd0:    cmd = 8'h30;
            4'd1:    cmd = 8'h30;
            4'd2:    cmd = 8'h30;
            4'd3:    cmd = 8'h20;
            4'd4:    cmd = 8'h28;
            4'd5:    cmd = 8'h08;
            4'd6:    cmd = 8'h01;
            4'd7:    cmd = 8'h06;
            4'd8:    cmd = 8'h0C;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

// ----- design/char_lcd_nibble_writer.sv -----
// Top level of the character LCD nibble writer: timing registers and wiring.
// Depends on clnw_pkg, clnw_front, clnw_queue and clnw_back.
//
// Channel   Direction  Handshake               Contents
// in        input      in_valid / in_ready     func, byte_value, row, col, number
// out       output     out_valid / out_ready   reg_select, nibble, last
// config    input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// Each nibble strobe has a high and a low phase, paced by the strobe counter in the back
// end against the two timing registers; a byte takes two strobes plus one fetch.
// A request takes 0 to 18 strobes, none for an off-screen position or an unused code.
// A number goes through binary to decimal conversion, one shift-add-three step per bit,
// then a skip of leading zeros, overlapped with strobes of earlier requests in the queue.
// Reset clears all control state; both timing registers reset to 50000.
// A stalled result holds the next strobe; the queue lets the front end run ahead.
module char_lcd_nibble_writer
    import clnw_pkg::*;
#(
    parameter int COLUMNS     = CLNW_COLUMNS,
    parameter int QUEUE_DEPTH = CLNW_QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Request channel.
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               func,
    input  logic [7:0]               byte_value,
    input  logic [1:0]               row,
    input  logic [5:0]               col,
    input  logic [CLNW_NUMBER_W-1:0] number,
    // Result channel.
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     reg_select,
    output logic [3:0]               nibble,
    output logic                     last,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CLNW_ADDR_W-1:0]   paddr,
    input  logic [CLNW_DATA_W-1:0]   pwdata,
    output logic [CLNW_DATA_W-1:0]   prdata,
    output logic                     pready
);

    logic [CLNW_CFG_W-1:0] high_reg;
    logic [CLNW_CFG_W-1:0] low_reg;
    logic                  cfg_write;
    strobe_cfg_t           strobe_cfg;
    logic                  push;
    byte_entry_t           push_entry;
    logic                  full;
    logic                  pop;
    byte_entry_t           head;
    logic                  empty;

    // Timing registers, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= CLNW_STROBE_RESET;
            low_reg  <= CLNW_STROBE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_STROBE_HIGH)
            begin
                high_reg <= pwdata[CLNW_CFG_W-1:0];
            end
            else
            begin
                low_reg <= pwdata[CLNW_CFG_W-1:0];
            end
        end
    end

    // Register read back.
    always_comb
    begin
        if (paddr[2] == REG_STROBE_LOW)
        begin
            prdata = {(CLNW_DATA_W - CLNW_CFG_W)'(0), low_reg};
        end
        else
        begin
            prdata = {(CLNW_DATA_W - CLNW_CFG_W)'(0), high_reg};
        end
    end

    assign strobe_cfg.high_cycles = high_reg;
    assign strobe_cfg.low_cycles  = low_reg;

    clnw_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .byte_value (byte_value),
        .row        (row),
        .col        (col),
        .number     (number),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    clnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    clnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .strobe_cfg (strobe_cfg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last)
    );

endmodule

// ----- design/clnw_front.sv -----
// Front end: accepts requests, decodes them and turns them into a byte list.
// Depends on clnw_pkg; feeds clnw_queue.
module clnw_front
    import clnw_pkg::*;
#(
    parameter int COLUMNS = CLNW_COLUMNS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               func,
    input  logic [7:0]               byte_value,
    input  logic [1:0]               row,
    input  logic [5:0]               col,
    input  logic [CLNW_NUMBER_W-1:0] number,
    output logic                     push,
    output byte_entry_t              push_entry,
    input  logic                     full
);

    localparam logic [6:0] COL_LIMIT = 7'(COLUMNS);
    localparam int         STEP_W    = $clog2(CLNW_NUMBER_W);
    localparam int         DIG_W     = $clog2(CLNW_DIGITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CLNW_NUMBER_W - 1);
    localparam logic [DIG_W-1:0]  TOP_DIGIT = DIG_W'(CLNW_DIGITS - 1);
    localparam logic [3:0]        LAST_INIT = 4'(CLNW_INIT_LEN - 1);

    front_state_t              state_reg, state_next;
    byte_entry_t               send_reg, send_next;
    logic [CLNW_NUMBER_W-1:0]  bin_reg, bin_next;
    logic [3:0]                digit_reg [CLNW_DIGITS];
    logic [3:0]                digit_next [CLNW_DIGITS];
    logic [3:0]                adj [CLNW_DIGITS];
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [DIG_W-1:0]          dig_idx_reg, dig_idx_next;
    logic [3:0]                init_idx_reg, init_idx_next;
    logic [3:0]                cur_digit;

    // Add three to every BCD digit of five or more before the next shift.
    always_comb
    begin
        for (int k = 0; k < CLNW_DIGITS; k++)
        begin
            adj[k] = (digit_reg[k] >= 4'd5) ? digit_reg[k] + 4'd3 : digit_reg[k];
        end
    end

    assign cur_digit = digit_reg[dig_idx_reg];
    assign in_ready  = (state_reg == F_IDLE);

    // Next state and byte output.
    always_comb
    begin
        state_next    = state_reg;
        send_next     = send_reg;
        bin_next      = bin_reg;
        digit_next    = digit_reg;
        step_next     = step_reg;
        dig_idx_next  = dig_idx_reg;
        init_idx_next = init_idx_reg;
        push          = 1'b0;
        push_entry    = '0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func_t'(func))
                        FUNC_CMD:
                        begin
                            send_next  = '{rs: 1'b0, value: byte_value, last: 1'b1};
                            state_next = F_SEND;
                        end
                        FUNC_DATA:
                        begin
                            send_next  = '{rs: 1'b1, value: byte_value, last: 1'b1};
                            state_next = F_SEND;
                        end
                        FUNC_POS:
                        begin
                            // Only the first two rows and columns on screen move the cursor.
                            if (!row[1] && ({1'b0, col} < COL_LIMIT))
                            begin
                                send_next.rs    = 1'b0;
                                send_next.value = (row[0] ? ROW1_BASE : ROW0_BASE)
                                                  + {2'b00, col};
                                send_next.last  = 1'b1;
                                state_next      = F_SEND;
                            end
                        end
                        FUNC_NUM:
                        begin
                            bin_next  = number;
                            step_next = '0;
                            for (int k = 0; k < CLNW_DIGITS; k++)
                            begin
                                digit_next[k] = 4'd0;
                            end
                            state_next = F_CONV;
                        end
                        FUNC_INIT:
                        begin
                            init_idx_next = 4'd0;
                            state_next    = F_INIT;
                        end
                        default:
                        begin
                            state_next = F_IDLE;
                        end
                    endcase
                end
            end

            F_SEND:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_entry = send_reg;
                    state_next = F_IDLE;
                end
            end

            F_INIT:
            begin
                if (!full)
                begin
                    push             = 1'b1;
                    push_entry.rs    = 1'b0;
                    push_entry.value = init_cmd(init_idx_reg);
                    push_entry.last  = (init_idx_reg == LAST_INIT);
                    if (init_idx_reg == LAST_INIT)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        init_idx_next = init_idx_reg + 4'd1;
                    end
                end
            end

            F_CONV:
            begin
                // One shift-add-three step per cycle, most significant bit first.
                digit_next[0] = {adj[0][2:0], bin_reg[CLNW_NUMBER_W-1]};
                for (int k = 1; k < CLNW_DIGITS; k++)
                begin
                    digit_next[k] = {adj[k][2:0], adj[k-1][3]};
                end
                bin_next  = {bin_reg[CLNW_NUMBER_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    dig_idx_next = TOP_DIGIT;
                    state_next   = F_SKIP;
                end
            end

            F_SKIP:
            begin
                // Drop leading zeros but keep the units digit.
                if ((cur_digit == 4'd0) && (dig_idx_reg != '0))
                begin
                    dig_idx_next = dig_idx_reg - 1'b1;
                end
                else
                begin
                    state_next = F_DIGITS;
                end
            end

            F_DIGITS:
            begin
                if (!full)
                begin
                    push             = 1'b1;
                    push_entry.rs    = 1'b1;
                    push_entry.value = ASCII_ZERO | {4'd0, cur_digit};
                    push_entry.last  = (dig_idx_reg == '0);
                    if (dig_idx_reg == '0)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        dig_idx_next = dig_idx_reg - 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        send_reg     <= send_next;
        bin_reg      <= bin_next;
        digit_reg    <= digit_next;
        step_reg     <= step_next;
        dig_idx_reg  <= dig_idx_next;
        init_idx_reg <= init_idx_next;
    end

endmodule

// ----- design/clnw_queue.sv -----
// Short byte queue between the front end and the strobe back end.
// Depends on clnw_pkg and the assertion macro header.
`include "char_lcd_nibble_writer_defines.svh"

module clnw_queue
    import clnw_pkg::*;
#(
    parameter int DEPTH = CLNW_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output byte_entry_t head,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    byte_entry_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Checks on queue use by both neighbors and on the fill count.
    `CLNW_ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, push, !full)
    `CLNW_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst_n, pop, !empty)
    `CLNW_ASSERT_ALWAYS(a_count_bounded, clk, rst_n, count_reg <= DEPTH_C)
    `CLNW_ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- design/clnw_back.sv -----
// Back end: sends each queued byte as two paced nibble strobes.
// Depends on clnw_pkg; drains clnw_queue and drives the result channel.
module clnw_back
    import clnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  byte_entry_t head,
    input  logic        empty,
    output logic        pop,
    input  strobe_cfg_t strobe_cfg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic        last
);

    back_state_t            state_reg, state_next;
    byte_entry_t            cur_reg, cur_next;
    logic                   half_reg, half_next;
    logic [CLNW_CFG_W-1:0]  cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   rs_reg, rs_next;
    logic [3:0]             nibble_reg, nibble_next;
    logic                   last_reg, last_next;
    logic                   slot_free;
    logic                   load;

    assign slot_free = !out_valid_reg || out_ready;

    // Strobe sequencer: fetch a byte, then high and low phases per nibble.
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        half_next  = half_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        load       = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    half_next  = 1'b0;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    cnt_next   = CLNW_CFG_W'(1);
                    state_next = B_HIGH;
                end
            end
            B_HIGH:
            begin
                if (cnt_reg >= strobe_cfg.high_cycles)
                begin
                    cnt_next   = CLNW_CFG_W'(1);
                    state_next = B_LOW;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            B_LOW:
            begin
                if (cnt_reg >= strobe_cfg.low_cycles)
                begin
                    if (!half_reg)
                    begin
                        half_next  = 1'b1;
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Result register, loaded as each strobe starts.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        rs_next        = rs_reg;
        nibble_next    = nibble_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            rs_next        = cur_reg.rs;
            nibble_next    = half_reg ? cur_reg.value[3:0] : cur_reg.value[7:4];
            last_next      = cur_reg.last && half_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        half_reg   <= half_next;
        cnt_reg    <= cnt_next;
        rs_reg     <= rs_next;
        nibble_reg <= nibble_next;
        last_reg   <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nibble_reg;
    assign last       = last_reg;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the character LCD nibble writer: directed requests, then random
// ones, with every nibble strobe compared against expected strobes, typed in or from a predictor.
// Depends on clnw_pkg and char_lcd_nibble_writer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clnw_pkg::*;

    localparam int CLK_HALF_NS     = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int RANDOM_PHASES   = 4;
    localparam int REPORT_LIMIT    = 10;
    localparam int MAX_STALL       = 24;
    localparam int LCD_COLUMNS     = CLNW_COLUMNS;
    localparam int LCD_INIT_LEN    = 9;

    // Command bytes of the power-up sequence, first byte in the top bits.
    localparam logic [71:0] LCD_INIT_BYTES = 72'h30_30_30_20_28_08_01_06_0C;

    // Operation codes that the block does not define.
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam logic [CLNW_CFG_W-1:0] STROBE_MIN = 24'd1;
    localparam logic [CLNW_CFG_W-1:0] STROBE_MAX = 24'hFFFFFF;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam bit CHECK_TYPED     = 1'b1;
    localparam bit CHECK_PREDICTED = 1'b0;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  byte_value;
        logic [1:0]  row;
        logic [5:0]  col;
        logic [15:0] number;
    } lcd_request_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } lcd_strobe_t;

    // One directed request; typed rows carry their byte stream, first byte in the top bits.
    typedef struct {
        lcd_request_t req;
        bit           typed;
        logic         rs;
        int           len;
        logic [39:0]  bytes;
    } directed_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [2:0]               func = 3'd0;
    logic [7:0]               byte_value = 8'd0;
    logic [1:0]               row = 2'd0;
    logic [5:0]               col = 6'd0;
    logic [CLNW_NUMBER_W-1:0] number = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     reg_select;
    logic [3:0]               nibble;
    logic                     last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CLNW_ADDR_W-1:0]   paddr = '0;
    logic [CLNW_DATA_W-1:0]   pwdata = '0;
    logic [CLNW_DATA_W-1:0]   prdata;
    logic                     pready;

    lcd_strobe_t   pending_strobes[$];
    directed_row_t directed_rows[$];

    logic [CLNW_CFG_W-1:0] strobe_high = CLNW_STROBE_RESET;
    logic [CLNW_CFG_W-1:0] strobe_low = CLNW_STROBE_RESET;

    int error_count = 0;
    int report_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_mode_cycles = 0;
    int rx_stall_left = 0;

    char_lcd_nibble_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .byte_value (byte_value),
        .row        (row),
        .col        (col),
        .number     (number),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .nibble     (nibble),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Counts a failure and tells the caller whether it is still worth printing.
    function automatic bit log_failure();
        error_count++;
        if (report_count < REPORT_LIMIT)
        begin
            report_count++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // A byte leaves the bus as two strobes, high nibble first.
    function automatic void queue_byte_strobes(input logic rs, input logic [7:0] value,
                                               input bit is_last);
        pending_strobes.push_back('{rs: rs, nib: value[7:4], last: 1'b0});
        pending_strobes.push_back('{rs: rs, nib: value[3:0], last: is_last});
    endfunction

    function automatic void queue_typed_bytes(input logic rs, input int len,
                                              input logic [39:0] bytes);
        int k;
        for (k = 0; k < len; k++)
        begin
            queue_byte_strobes(rs, bytes[39-8*k -: 8], k == len - 1);
        end
    endfunction

    // Works out the bytes one request puts on the bus and queues their strobes.
    function automatic int queue_lcd_strobes(input lcd_request_t req);
        logic [7:0] seq[$];
        logic       rs;
        int         value;
        int         k;
        rs = RS_CMD;
        value = int'(req.number);
        case (req.func)
            FUNC_CMD:
            begin
                seq.push_back(req.byte_value);
            end
            FUNC_DATA:
            begin
                rs = RS_DATA;
                seq.push_back(req.byte_value);
            end
            FUNC_POS:
            begin
                // Positions off the 2 x COLUMNS screen are dropped silently.
                if (req.row < 2'd2 && int'(req.col) < LCD_COLUMNS)
                begin
                    seq.push_back((req.row == 2'd0 ? ROW0_BASE : ROW1_BASE) + 8'(req.col));
                end
            end
            FUNC_NUM:
            begin
                // Decimal digits, most significant first; zero prints a single digit.
                rs = RS_DATA;
                do
                begin
                    seq.push_front(ASCII_ZERO + 8'(value % 10));
                    value = value / 10;
                end
                while (value != 0);
            end
            FUNC_INIT:
            begin
                for (k = 0; k < LCD_INIT_LEN; k++)
                begin
                    seq.push_back(LCD_INIT_BYTES[71-8*k -: 8]);
                end
            end
            default:
            begin
            end
        endcase
        for (k = 0; k < seq.size(); k++)
        begin
            queue_byte_strobes(rs, seq[k], k == seq.size() - 1);
        end
        return 2 * seq.size();
    endfunction

    function automatic void add_row(input logic [2:0] f, input logic [7:0] b,
                                    input logic [1:0] r, input logic [5:0] c,
                                    input logic [15:0] n, input bit typed, input logic rs,
                                    input int len, input logic [39:0] bytes);
        directed_row_t entry;
        entry.req = '{func: f, byte_value: b, row: r, col: c, number: n};
        entry.typed = typed;
        entry.rs = rs;
        entry.len = len;
        entry.bytes = bytes;
        directed_rows.push_back(entry);
    endfunction

    function automatic lcd_request_t make_random_request();
        lcd_request_t req;
        int           pick;
        // Fields that the operation ignores still carry random values.
        req.func = FUNC_CMD;
        req.byte_value = 8'($urandom);
        req.row = 2'($urandom);
        req.col = 6'($urandom);
        req.number = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            req.func = FUNC_CMD;
        end
        else if (pick < 50)
        begin
            req.func = FUNC_DATA;
        end
        else if (pick < 65)
        begin
            req.func = FUNC_POS;
            req.row = 2'($urandom_range(0, 1));
            req.col = 6'($urandom_range(0, LCD_COLUMNS - 1));
        end
        else if (pick < 70)
        begin
            // Off-screen position: bad row or column past the edge.
            req.func = FUNC_POS;
            if ($urandom_range(0, 1) == 0)
            begin
                req.row = 2'($urandom_range(2, 3));
            end
            else
            begin
                req.row = 2'($urandom_range(0, 1));
                req.col = 6'($urandom_range(LCD_COLUMNS, 63));
            end
        end
        else if (pick < 85)
        begin
            req.func = FUNC_NUM;
            case ($urandom_range(0, 3))
                0:       req.number = 16'($urandom_range(0, 9));
                1:       req.number = 16'($urandom_range(0, 999));
                default: req.number = 16'($urandom);
            endcase
        end
        else if (pick < 92)
        begin
            req.func = FUNC_INIT;
        end
        else
        begin
            req.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        end
        return req;
    endfunction

    function automatic int settle_cycles();
        return 2 * (int'(strobe_high) + int'(strobe_low) + 2) + 48;
    endfunction

    // Register write: setup cycle, then access cycle.
    task automatic apb_write(input logic idx, input logic [CLNW_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(input logic idx, input logic [CLNW_CFG_W-1:0] want);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {8'h00, want})
        begin
            if (log_failure())
            begin
                $display("register %0d read: expected %h, got %h", idx, {8'h00, want}, prdata);
            end
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper data bits are junk; only the low 24 bits belong to a timing register.
    task automatic set_strobe_timing(input logic [CLNW_CFG_W-1:0] high_cycles,
                                     input logic [CLNW_CFG_W-1:0] low_cycles);
        apb_write(REG_STROBE_HIGH, {8'($urandom), high_cycles});
        apb_write(REG_STROBE_LOW, {8'($urandom), low_cycles});
        strobe_high = high_cycles;
        strobe_low = low_cycles;
        check_register(REG_STROBE_HIGH, high_cycles);
        check_register(REG_STROBE_LOW, low_cycles);
    endtask

    // Sender works in bursts; between bursts valid drops for a random gap, sometimes none.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // Presents one request and holds it until it is accepted.
    task automatic send_request(input lcd_request_t req);
        @(negedge clk);
        in_valid <= 1'b1;
        func <= req.func;
        byte_value <= req.byte_value;
        row <= req.row;
        col <= req.col;
        number <= req.number;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds off new requests until every strobe is out and the block has gone quiet.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_strobes.size() != 0)
            @(posedge clk);
        repeat (settle_cycles()) @(posedge clk);
    endtask

    // Receiver stalls follow one of four modes, taken in turn.
    always @(negedge clk)
    begin
        if (rx_mode_cycles == 0)
        begin
            rx_mode = (rx_mode + 1) % 4;
            rx_mode_cycles = $urandom_range(100, 300);
        end
        else
        begin
            rx_mode_cycles--;
        end
        if (rx_stall_left == 0)
        begin
            case (rx_mode)
                1:       rx_stall_left = $urandom_range(0, 1);
                2:       rx_stall_left = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 3) : 0;
                3:       rx_stall_left = ($urandom_range(0, 7) == 0) ?
                                         $urandom_range(4, MAX_STALL) : 0;
                default: rx_stall_left = 0;
            endcase
        end
        if (rx_stall_left > 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each strobe taken from the bus with the oldest expected one.
    always @(posedge clk)
    begin
        lcd_strobe_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_strobes.size() == 0)
            begin
                if (log_failure())
                begin
                    $display("unexpected strobe: rs %b nibble %h last %b",
                             reg_select, nibble, last);
                end
            end
            else
            begin
                want = pending_strobes.pop_front();
                if (want.rs !== reg_select || want.nib !== nibble || want.last !== last)
                begin
                    if (log_failure())
                    begin
                        $display({"strobe mismatch: expected rs %b nibble %h last %b, ",
                                  "got rs %b nibble %h last %b"},
                                 want.rs, want.nib, want.last, reg_select, nibble, last);
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        lcd_request_t req;
        int           idx;
        int           phase;
        int           phase_items;
        logic [CLNW_CFG_W-1:0] high_pick;
        logic [CLNW_CFG_W-1:0] low_pick;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset values, then both extremes of the timing registers while idle.
        check_register(REG_STROBE_HIGH, CLNW_STROBE_RESET);
        check_register(REG_STROBE_LOW, CLNW_STROBE_RESET);
        set_strobe_timing(STROBE_MAX, STROBE_MAX);
        set_strobe_timing(STROBE_MIN, STROBE_MIN);

        // Directed requests: field extremes, screen edges, digit counts and unused codes.
        add_row(FUNC_CMD, 8'h00, 2'd3, 6'd63, 16'hFFFF, CHECK_TYPED, RS_CMD, 1, 40'h00_00000000);
        add_row(FUNC_CMD, 8'hFF, 2'd0, 6'd0, 16'h0000, CHECK_TYPED, RS_CMD, 1, 40'hFF_00000000);
        add_row(FUNC_DATA, 8'h00, 2'd3, 6'd63, 16'hFFFF, CHECK_TYPED, RS_DATA, 1,
                40'h00_00000000);
        add_row(FUNC_DATA, 8'hFF, 2'd0, 6'd0, 16'h0000, CHECK_TYPED, RS_DATA, 1,
                40'hFF_00000000);
        add_row(FUNC_DATA, 8'hA5, 2'd2, 6'd21, 16'h5A5A, CHECK_PREDICTED, RS_DATA, 0, '0);
        add_row(FUNC_POS, 8'hFF, 2'd0, 6'd0, 16'hFFFF, CHECK_TYPED, RS_CMD, 1, 40'h80_00000000);
        add_row(FUNC_POS, 8'h00, 2'd1, 6'd15, 16'h0000, CHECK_TYPED, RS_CMD, 1, 40'hCF_00000000);
        add_row(FUNC_POS, 8'h3C, 2'd0, 6'd15, 16'h1234, CHECK_TYPED, RS_CMD, 1, 40'h8F_00000000);
        add_row(FUNC_POS, 8'hC3, 2'd1, 6'd0, 16'h4321, CHECK_TYPED, RS_CMD, 1, 40'hC0_00000000);
        add_row(FUNC_POS, 8'h11, 2'd2, 6'd3, 16'h0001, CHECK_TYPED, RS_CMD, 0, '0);
        add_row(FUNC_POS, 8'h22, 2'd3, 6'd63, 16'h0002, CHECK_TYPED, RS_CMD, 0, '0);
        add_row(FUNC_POS, 8'h33, 2'd0, 6'd16, 16'h0003, CHECK_TYPED, RS_CMD, 0, '0);
        add_row(FUNC_POS, 8'h44, 2'd1, 6'd63, 16'h0004, CHECK_TYPED, RS_CMD, 0, '0);
        add_row(FUNC_NUM, 8'hFF, 2'd3, 6'd63, 16'd0, CHECK_TYPED, RS_DATA, 1, 40'h30_00000000);
        add_row(FUNC_NUM, 8'h00, 2'd0, 6'd0, 16'd65535, CHECK_TYPED, RS_DATA, 5,
                40'h36_35_35_33_35);
        add_row(FUNC_NUM, 8'h5A, 2'd1, 6'd7, 16'd10, CHECK_TYPED, RS_DATA, 2, 40'h31_30_000000);
        add_row(FUNC_NUM, 8'hA5, 2'd2, 6'd40, 16'd9, CHECK_TYPED, RS_DATA, 1, 40'h39_00000000);
        add_row(FUNC_NUM, 8'h0F, 2'd1, 6'd1, 16'd10000, CHECK_TYPED, RS_DATA, 5,
                40'h31_30_30_30_30);
        add_row(FUNC_NUM, 8'hF0, 2'd0, 6'd9, 16'd1234, CHECK_PREDICTED, RS_DATA, 0, '0);
        add_row(FUNC_INIT, 8'h77, 2'd3, 6'd33, 16'hBEEF, CHECK_PREDICTED, RS_CMD, 0, '0);
        add_row(FUNC_SPARE_LO, 8'hFF, 2'd1, 6'd5, 16'd7, CHECK_TYPED, RS_CMD, 0, '0);
        add_row(FUNC_SPARE_MID, 8'h00, 2'd0, 6'd2, 16'd0, CHECK_TYPED, RS_CMD, 0, '0);
        add_row(FUNC_SPARE_HI, 8'h81, 2'd3, 6'd63, 16'hFFFF, CHECK_TYPED, RS_CMD, 0, '0);

        for (idx = 0; idx < directed_rows.size(); idx++)
        begin
            pace_sender();
            send_request(directed_rows[idx].req);
            if (directed_rows[idx].typed)
            begin
                queue_typed_bytes(directed_rows[idx].rs, directed_rows[idx].len,
                                  directed_rows[idx].bytes);
            end
            else
            begin
                void'(queue_lcd_strobes(directed_rows[idx].req));
            end
        end
        drain_block();

        // Random requests, one timing setting per phase; the sender pauses between phases
        // until every strobe has come out.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    high_pick = STROBE_MIN;
                    low_pick = 24'd8;
                end
                1:
                begin
                    high_pick = 24'd8;
                    low_pick = STROBE_MIN;
                end
                default:
                begin
                    high_pick = 24'($urandom_range(1, 8));
                    low_pick = 24'($urandom_range(1, 8));
                end
            endcase
            set_strobe_timing(high_pick, low_pick);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                req = make_random_request();
                pace_sender();
                send_request(req);
                if (queue_lcd_strobes(req) > 0)
                begin
                    phase_items++;
                end
            end
            drain_block();
        end

        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
